@@ sv/ist_pkg.sv @@
`default_nettype none

package ist_pkg;

  // store depth and widths
  localparam int CAPACITY      = 64;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int ELEM_W        = 32;
  localparam int COUNT_FIELD_W = 7;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [ELEM_W-1:0] element_value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     is_member;
    logic [COUNT_FIELD_W-1:0] element_count;
    logic                     set_empty;
    logic signed [ELEM_W-1:0] largest_value;
    logic signed [ELEM_W-1:0] smallest_value;
    logic                     extremes_valid;
  } rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic probe;
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/ist_cell.sv @@
`default_nettype none

module ist_cell (
  input  wire logic               clk,
  input  wire ist_pkg::cell_ctrl_t ctrl,
  input  wire ist_pkg::elem_t      probe,
  input  wire ist_pkg::elem_t      key,
  input  wire logic               occupied,
  input  wire ist_pkg::elem_t      left_value,
  input  wire ist_pkg::elem_t      right_value,
  input  wire logic               left_beyond,
  output ist_pkg::elem_t           value,
  output logic                    beyond,
  output logic                    hit
);

  logic           occ;
  logic           eq;
  logic           lt;
  logic           take_right;
  ist_pkg::elem_t value_next;

  // compare flags captured with the incoming item
  always_ff @(posedge clk) begin
    if (ctrl.probe) begin
      occ <= occupied;
      eq  <= (probe == value);
      lt  <= (probe < value);
    end
  end

  // cell sits above the insertion point
  assign beyond     = !occ || lt;
  assign hit        = occ && eq;
  // cell sits at or above the removed entry
  assign take_right = occ && (eq || lt);

  always_comb begin
    value_next = value;
    priority if (ctrl.insert && beyond) begin
      value_next = left_beyond ? left_value : key;
    end else if (ctrl.remove && take_right) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

@@ sv/ist_extremes.sv @@
`default_nettype none

module ist_extremes (
  input  wire ist_pkg::elem_t values [ist_pkg::CAPACITY],
  input  wire ist_pkg::cnt_t  count,
  output ist_pkg::elem_t      largest,
  output ist_pkg::elem_t      smallest
);

  // sorted row: head holds the minimum, the last occupied cell the maximum
  always_comb begin
    largest = '0;
    for (int i = 0; i < ist_pkg::CAPACITY; i++) begin
      largest = largest | (values[i] & {ist_pkg::ELEM_W{count == ist_pkg::cnt_t'(i + 1)}});
    end
  end

  assign smallest = (count != '0) ? values[0] : '0;

endmodule

`default_nettype wire

@@ sv/integer_set_table_top.sv @@
`default_nettype none

// channel | role   | handshake            | payload
// --------+--------+----------------------+-------------------------------
// req     | input  | req_valid/req_stall  | ist_pkg::req_t (action, value)
// rsp     | output | rsp_valid/rsp_stall  | ist_pkg::rsp_t (one per item)
//
// each item has a probe cycle, where every cell compares its entry against the value,
// then an update cycle, where a successful insert or remove shifts the row by one place
// the result is loaded into the output register in S_RESULT, which also takes the next item
// rst is synchronous: count, state and rsp_valid clear; cell entries stay undefined
// a stalled rsp holds its result; the item behind it may still be taken and updated,
// then its result waits in S_RESULT with req_stall high until rsp drains

module integer_set_table_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire ist_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ist_pkg::rsp_t      rsp
);

  ist_pkg::state_t     state;
  ist_pkg::state_t     state_next;
  ist_pkg::cell_ctrl_t ctrl;
  ist_pkg::req_t       req_q;
  ist_pkg::cnt_t       count;
  ist_pkg::cnt_t       count_next;
  logic [1:0]          status;
  logic [1:0]          status_next;
  logic                member;
  logic                member_next;

  logic                rsp_free;
  logic                take;
  logic                accept;
  logic                present;
  logic                full;

  // row wiring between neighboring cells
  ist_pkg::elem_t cell_value [ist_pkg::CAPACITY];
  logic [ist_pkg::CAPACITY-1:0] cell_beyond;
  logic [ist_pkg::CAPACITY-1:0] cell_hit;
  logic [ist_pkg::CAPACITY-1:0] occupied;

  ist_pkg::elem_t largest;
  ist_pkg::elem_t smallest;

  // the output register is free when empty or being drained this cycle
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign take     = (state == ist_pkg::S_RESULT) && rsp_free;
  assign accept   = req_valid && !req_stall;

  assign present = |cell_hit;
  assign full    = (count == ist_pkg::cnt_t'(ist_pkg::CAPACITY));

  // sequencer: next state and cell commands
  always_comb begin
    state_next  = state;
    req_stall   = 1'b1;
    ctrl        = '0;
    count_next  = count;
    status_next = status;
    member_next = member;
    unique case (state)
      ist_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          ctrl.probe = 1'b1;
          state_next = ist_pkg::S_UPDATE;
        end
      end
      ist_pkg::S_UPDATE: begin
        state_next = ist_pkg::S_RESULT;
        unique case (req_q.action)
          ist_pkg::ACT_INSERT: begin
            priority if (present) begin
              status_next = ist_pkg::ST_PRESENT;
              member_next = 1'b1;
            end else if (full) begin
              status_next = ist_pkg::ST_FULL;
              member_next = 1'b0;
            end else begin
              ctrl.insert = 1'b1;
              count_next  = count + 1'b1;
              status_next = ist_pkg::ST_DONE;
              member_next = 1'b1;
            end
          end
          ist_pkg::ACT_REMOVE: begin
            member_next = 1'b0;
            if (present) begin
              ctrl.remove = 1'b1;
              count_next  = count - 1'b1;
              status_next = ist_pkg::ST_DONE;
            end else begin
              status_next = ist_pkg::ST_ABSENT;
            end
          end
          default: begin
            // look up, and the unused code behaves the same
            status_next = present ? ist_pkg::ST_DONE : ist_pkg::ST_ABSENT;
            member_next = present;
          end
        endcase
      end
      ist_pkg::S_RESULT: begin
        if (take) begin
          req_stall  = 1'b0;
          ctrl.probe = req_valid;
          state_next = req_valid ? ist_pkg::S_UPDATE : ist_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ist_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // held item and outcome of the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    status <= status_next;
    member <= member_next;
  end

  // a cell is occupied when its index is below the count
  for (genvar i = 0; i < ist_pkg::CAPACITY; i++) begin : g_row
    ist_pkg::elem_t left_value;
    ist_pkg::elem_t right_value;
    logic           left_beyond;

    assign occupied[i] = (count > ist_pkg::cnt_t'(i));

    if (i == 0) begin : g_head
      assign left_value  = req_q.element_value;
      assign left_beyond = 1'b0;
    end else begin : g_inner_left
      assign left_value  = cell_value[i-1];
      assign left_beyond = cell_beyond[i-1];
    end

    if (i == ist_pkg::CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
    end

    ist_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .probe       (req.element_value),
      .key         (req_q.element_value),
      .occupied    (occupied[i]),
      .left_value  (left_value),
      .right_value (right_value),
      .left_beyond (left_beyond),
      .value       (cell_value[i]),
      .beyond      (cell_beyond[i]),
      .hit         (cell_hit[i])
    );
  end

  ist_extremes u_extremes (
    .values   (cell_value),
    .count    (count),
    .largest  (largest),
    .smallest (smallest)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.status         <= status;
      rsp.is_member      <= member;
      rsp.element_count  <= ist_pkg::COUNT_FIELD_W'(count);
      rsp.set_empty      <= (count == '0);
      rsp.largest_value  <= largest;
      rsp.smallest_value <= smallest;
      rsp.extremes_valid <= (count != '0);
    end
  end

endmodule

`default_nettype wire

@@ sv/ist_checker.sv @@
`default_nettype none

module ist_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire ist_pkg::rsp_t rsp
);

  // a stalled result holds until its transfer
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  // empty flag, count and extremes flag agree
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.set_empty == (rsp.element_count == '0)) &&
                  (rsp.extremes_valid == !rsp.set_empty))
    else $error("empty flag disagrees with count");

  // minimum never above maximum
  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.extremes_valid |-> rsp.smallest_value <= rsp.largest_value)
    else $error("smallest above largest");

  // empty set reports zero extremes
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.set_empty |-> rsp.largest_value == '0 && rsp.smallest_value == '0)
    else $error("nonzero extremes on empty set");

  // an absent value is never a member
  a_absent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ist_pkg::ST_ABSENT |-> !rsp.is_member)
    else $error("absent status with membership");

endmodule

bind integer_set_table_top ist_checker u_ist_checker (.*);

`default_nettype wire

@@ tb/sv/tb_integer_set_table_top.sv @@
`timescale 1ns / 100ps

module tb_integer_set_table_top;

  // action 3 is not decoded by the block and must behave as a look up
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 80;
  localparam int DRAIN_WAIT  = 8;

  localparam ist_pkg::elem_t INT_MIN_VAL = ist_pkg::elem_t'(32'h8000_0000);
  localparam ist_pkg::elem_t INT_MAX_VAL = ist_pkg::elem_t'(32'h7fff_ffff);

  logic           clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  ist_pkg::req_t  req       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  ist_pkg::rsp_t  rsp;

  // mirror of the stored set, kept in insertion order
  ist_pkg::elem_t held_values[$];
  ist_pkg::rsp_t  expected_rsp_q[$];
  ist_pkg::elem_t value_pool[POOL_SIZE];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int req_idle_pct   = 0;
  int rsp_stall_pct  = 0;

  integer_set_table_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run guard, counts every cycle from time zero
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver back-pressure, drawn fresh every cycle
  always @(posedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < rsp_stall_pct);
  end

  // applies one operation to the mirrored set and builds the result it should give
  function automatic ist_pkg::rsp_t apply_set_op(input ist_pkg::req_t r);
    ist_pkg::rsp_t  res;
    int             pos;
    bit             present;
    ist_pkg::elem_t hi;
    ist_pkg::elem_t lo;
    pos = -1;
    foreach (held_values[i]) begin
      if (pos < 0 && held_values[i] == r.element_value) pos = i;
    end
    present = (pos >= 0);
    res     = '0;
    case (r.action)
      ist_pkg::ACT_INSERT: begin
        if (present) begin
          res.status    = ist_pkg::ST_PRESENT;
          res.is_member = 1'b1;
        end else if (held_values.size() >= ist_pkg::CAPACITY) begin
          res.status    = ist_pkg::ST_FULL;
          res.is_member = 1'b0;
        end else begin
          held_values.push_back(r.element_value);
          res.status    = ist_pkg::ST_DONE;
          res.is_member = 1'b1;
        end
      end
      ist_pkg::ACT_REMOVE: begin
        // later slots move down by one to close the gap
        if (present) begin
          held_values.delete(pos);
          res.status = ist_pkg::ST_DONE;
        end else begin
          res.status = ist_pkg::ST_ABSENT;
        end
        res.is_member = 1'b0;
      end
      default: begin
        res.status    = present ? ist_pkg::ST_DONE : ist_pkg::ST_ABSENT;
        res.is_member = present;
      end
    endcase
    hi = '0;
    lo = '0;
    if (held_values.size() > 0) begin
      hi = held_values[0];
      lo = held_values[0];
      foreach (held_values[i]) begin
        if (held_values[i] > hi) hi = held_values[i];
        if (held_values[i] < lo) lo = held_values[i];
      end
    end
    res.element_count  = ist_pkg::COUNT_FIELD_W'(held_values.size());
    res.set_empty      = (held_values.size() == 0);
    res.largest_value  = hi;
    res.smallest_value = lo;
    res.extremes_valid = (held_values.size() > 0);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // result checker and request predictor, both on accepted transfers only
  always @(posedge clk) begin : monitor
    ist_pkg::rsp_t exp_rsp;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %p", $time, rsp);
          mismatch_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          check_field("status", 32'(exp_rsp.status), 32'(rsp.status));
          check_field("is_member", 32'(exp_rsp.is_member), 32'(rsp.is_member));
          check_field("element_count", 32'(exp_rsp.element_count),
                      32'(rsp.element_count));
          check_field("set_empty", 32'(exp_rsp.set_empty), 32'(rsp.set_empty));
          check_field("largest_value", exp_rsp.largest_value, rsp.largest_value);
          check_field("smallest_value", exp_rsp.smallest_value, rsp.smallest_value);
          check_field("extremes_valid", 32'(exp_rsp.extremes_valid),
                      32'(rsp.extremes_valid));
        end
      end
      // the new request is predicted after any result at this edge is retired
      if (req_valid && !req_stall) expected_rsp_q.push_back(apply_set_op(req));
    end
  end

  // one request transfer, with an optional idle gap in front of it
  task automatic send_request(input logic [1:0] action, input ist_pkg::elem_t value);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < req_idle_pct) gap++;
    if (gap > 0) begin
      if (req_valid) req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid           <= 1'b1;
    req.action          <= action;
    req.element_value   <= value;
    do @(posedge clk); while (req_stall);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_for_drain();
    if (req_valid) req_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  function automatic ist_pkg::elem_t pick_value();
    if ($urandom_range(99) < 85) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return ist_pkg::elem_t'($urandom);
  endfunction

  // extremes of the value range, every action, and the named corner cases
  task automatic test_directed();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    send_request(ist_pkg::ACT_LOOKUP, 5);            // look up on empty set
    send_request(ist_pkg::ACT_REMOVE, 5);            // remove on empty set
    send_request(ACT_UNUSED, 0);                     // unused selector, empty set
    send_request(ist_pkg::ACT_INSERT, INT_MIN_VAL);
    send_request(ist_pkg::ACT_INSERT, INT_MAX_VAL);
    send_request(ist_pkg::ACT_INSERT, 0);
    send_request(ist_pkg::ACT_INSERT, -1);
    send_request(ist_pkg::ACT_INSERT, 0);            // duplicate insert
    send_request(ist_pkg::ACT_LOOKUP, -1);
    send_request(ACT_UNUSED, INT_MAX_VAL);           // unused selector, present value
    send_request(ACT_UNUSED, 7);                     // unused selector, absent value
    send_request(ist_pkg::ACT_REMOVE, 7);            // remove of absent value
    send_request(ist_pkg::ACT_REMOVE, 0);            // middle slot
    send_request(ist_pkg::ACT_REMOVE, INT_MIN_VAL);  // first slot
    send_request(ist_pkg::ACT_LOOKUP, INT_MIN_VAL);
    send_request(ist_pkg::ACT_REMOVE, -1);           // first slot
    send_request(ist_pkg::ACT_INSERT, ist_pkg::elem_t'(32'h5555_5555));
    send_request(ist_pkg::ACT_INSERT, ist_pkg::elem_t'(32'haaaa_aaaa));
    send_request(ist_pkg::ACT_REMOVE, INT_MAX_VAL);
    send_request(ist_pkg::ACT_REMOVE, ist_pkg::elem_t'(32'h5555_5555));
    send_request(ist_pkg::ACT_REMOVE, ist_pkg::elem_t'(32'haaaa_aaaa)); // back to empty
    wait_for_drain();
  endtask

  // fill the store, push past capacity, then empty it again out of order
  task automatic test_capacity();
    ist_pkg::elem_t fill_vals[ist_pkg::CAPACITY];
    req_idle_pct  = 20;
    rsp_stall_pct = 20;
    // odd multiplier keeps the values distinct
    for (int i = 0; i < ist_pkg::CAPACITY; i++)
      fill_vals[i] = ist_pkg::elem_t'(i * 32'h0301_0007 ^ 32'h8000_0000);
    for (int i = 0; i < ist_pkg::CAPACITY; i++)
      send_request(ist_pkg::ACT_INSERT, fill_vals[i]);
    send_request(ist_pkg::ACT_INSERT, 12345);                          // refused, store full
    send_request(ist_pkg::ACT_INSERT, fill_vals[ist_pkg::CAPACITY/2]); // present wins over full
    send_request(ist_pkg::ACT_LOOKUP, fill_vals[ist_pkg::CAPACITY-1]);
    send_request(ist_pkg::ACT_REMOVE, fill_vals[0]);
    send_request(ist_pkg::ACT_INSERT, 12345);
    send_request(ist_pkg::ACT_INSERT, 54321);                          // full again
    send_request(ist_pkg::ACT_REMOVE, 12345);
    for (int i = 1; i < ist_pkg::CAPACITY; i += 2)
      send_request(ist_pkg::ACT_REMOVE, fill_vals[i]);
    for (int i = ist_pkg::CAPACITY - 2; i > 0; i -= 2)
      send_request(ist_pkg::ACT_REMOVE, fill_vals[i]);
    wait_for_drain();
  endtask

  function automatic ist_pkg::req_t make_random_item(input bit grow);
    ist_pkg::req_t r;
    int            roll;
    roll = $urandom_range(99);
    // a little pure noise over every action and value bit
    if (roll < 8) begin
      r.action        = 2'($urandom_range(3));
      r.element_value = ist_pkg::elem_t'($urandom);
      return r;
    end
    roll = $urandom_range(99);
    if (roll < 5)                     r.action = ACT_UNUSED;
    else if (roll < 20)               r.action = ist_pkg::ACT_LOOKUP;
    else if (roll < (grow ? 80 : 40)) r.action = grow ? ist_pkg::ACT_INSERT : ist_pkg::ACT_REMOVE;
    else                              r.action = grow ? ist_pkg::ACT_REMOVE : ist_pkg::ACT_INSERT;
    if (r.action != ist_pkg::ACT_INSERT && held_values.size() > 0 && $urandom_range(99) < 60)
      r.element_value = held_values[$urandom_range(held_values.size() - 1)];
    else
      r.element_value = pick_value();
    return r;
  endfunction

  // random traffic in alternating stretches, each with the same mix weighted toward inserts
  task automatic test_random_phase(input int n_items, input int idle_pct, input int stall_p);
    ist_pkg::req_t item;
    req_idle_pct  = idle_pct;
    rsp_stall_pct = stall_p;
    for (int i = 0; i < n_items; i++) begin
      item = make_random_item(((i / 60) % 2) == 0);
      send_request(item.action, item.element_value);
    end
  endtask

  // sender holds off until every result is back, then resumes
  task automatic test_pause_until_drained();
    test_random_phase(20, 30, 30);
    wait_for_drain();
    test_random_phase(20, 0, 30);
  endtask

  initial begin : run
    value_pool[0] = INT_MIN_VAL;
    value_pool[1] = INT_MAX_VAL;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = ist_pkg::elem_t'($urandom);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_capacity();
    test_random_phase(300, 0, 0);
    test_random_phase(300, 56, 0);
    test_random_phase(300, 0, 56);
    test_random_phase(300, 18, 18);
    test_pause_until_drained();

    wait_for_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ integer_set_table_top.f @@
sv/ist_pkg.sv
sv/ist_cell.sv
sv/ist_extremes.sv
sv/integer_set_table_top.sv
sv/ist_checker.sv
tb/sv/tb_integer_set_table_top.sv
